@@ rtl/dda_pkg.sv @@
// Shared types and constants for the grid ray caster.
`default_nettype none
package dda_pkg;
    localparam int POS_W   = 22;
    localparam int DIST_W  = 24;
    localparam int HEAD_W  = 16;
    localparam int MAG_W   = 16;
    localparam int ACC_W   = 35;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 64;
    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
    localparam logic [POS_W-1:0]  POS_MAX  = 22'h3FFFFF;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_LEFT  = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic REG_WALL_MIN   = 1'b0;
    localparam logic REG_STEP_LIMIT = 1'b1;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } unit_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] result;
    } unit_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQ_GO, S_SQ_WAIT, S_DX_GO, S_DX_WAIT,
        S_DY_GO, S_DY_WAIT, S_REMX, S_REMY, S_STEP, S_BOUND, S_CHECK,
        S_HITX, S_HITY
    } state_t;
endpackage
`default_nettype wire

@@ rtl/dda_root_div.sv @@
// Shared iterative unit: floor square root or restoring divide, one bit per cycle.
`default_nettype none
module dda_root_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire dda_pkg::unit_req_t         req,
    input  wire logic [dda_pkg::RAD_W-1:0]  radicand,
    input  wire logic [dda_pkg::ROOT_W-1:0] dividend,
    input  wire logic [dda_pkg::MAG_W-1:0]  divisor,
    output dda_pkg::unit_rsp_t              rsp
);
    logic [dda_pkg::RAD_W-1:0]  rad_reg;
    logic [dda_pkg::ACC_W-1:0]  rem_reg;
    logic [dda_pkg::ROOT_W-1:0] q_reg;
    logic [dda_pkg::MAG_W-1:0]  dvs_reg;
    logic [4:0]                 cnt_reg;
    logic                       run_reg, sqrt_reg, done_reg;
    logic [dda_pkg::ACC_W-1:0]  a_op, b_op;
    logic [dda_pkg::ACC_W:0]    diff;
    logic                       ge;

    // Select trial remainder and subtrahend for the current mode
    always_comb begin
        if (sqrt_reg) begin
            a_op = {rem_reg[32:0], rad_reg[63:62]};
            b_op = {1'b0, q_reg, 2'b01};
        end else begin
            a_op = {18'd0, rem_reg[15:0], rad_reg[63]};
            b_op = {19'd0, dvs_reg};
        end
        diff = {1'b0, a_op} - {1'b0, b_op};
        ge   = ~diff[dda_pkg::ACC_W];
    end

    // Run one digit each cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg  <= 1'b1;
                sqrt_reg <= req.is_sqrt;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                q_reg    <= '0;
                dvs_reg  <= divisor;
                rad_reg  <= req.is_sqrt ? radicand : {dividend, 32'd0};
            end else if (run_reg) begin
                rem_reg <= ge ? diff[dda_pkg::ACC_W-1:0] : a_op;
                q_reg   <= {q_reg[dda_pkg::ROOT_W-2:0], ge};
                rad_reg <= sqrt_reg ? {rad_reg[61:0], 2'b00} : {rad_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(dda_pkg::ROOT_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg;
endmodule
`default_nettype wire

@@ rtl/dda_map.sv @@
// Tile map memory with one write port and one registered read port.
`default_nettype none
module dda_map #(
    parameter int MAP_SIDE = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] wr_addr,
    input  wire logic [7:0]                           wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] rd_addr,
    output logic [7:0]                                rd_data
);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    logic [7:0] mem [DEPTH];

    // Write and read the tile store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/dda_grid_ray_caster.sv @@
// Grid ray caster top level: sequencer, shared multiplier and result register.
// A tile write goes from idle to the result state. A cast squares the heading in the
// shared multiplier, takes root and one divide per nonzero heading component in the
// shared root/divide unit, multiplies remainders, steps the grid (step, bound, check)
// and multiplies out the hit point. One item at a time; the next waits for idle only.
// Reset (aresetn, synchronous) sets wall_min_value 1, step_limit 128; map is not reset.
`default_nettype none
module dda_grid_ray_caster #(
    parameter int MAP_SIDE = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [7:0]   cfg_wdata,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_opcode,
    input  wire logic [5:0]   s_tile_col,
    input  wire logic [5:0]   s_tile_row,
    input  wire logic [7:0]   s_tile_value,
    input  wire logic [21:0]  s_origin_x,
    input  wire logic [21:0]  s_origin_y,
    input  wire logic signed [15:0] s_heading_x,
    input  wire logic signed [15:0] s_heading_y,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_status,
    output logic [7:0]        m_hit_tile,
    output logic [23:0]       m_hit_distance,
    output logic [21:0]       m_hit_x,
    output logic [21:0]       m_hit_y
);
    localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);

    dda_pkg::state_t state_reg, state_next;

    logic [7:0]  wall_min_reg, step_limit_reg;
    logic [21:0] ox_reg, oy_reg;
    logic [15:0] ax_reg, ay_reg;
    logic        nx_reg, ny_reg;
    logic [31:0] sumsq_reg;
    logic [31:0] root_reg;
    logic [23:0] sx_reg, sy_reg;
    logic [33:0] rx_reg, ry_reg, dist_reg;
    logic signed [7:0] tx_reg, ty_reg;
    logic [7:0]  count_reg;
    logic [1:0]  status_reg;
    logic [7:0]  tile_reg;
    logic [21:0] hx_reg;

    logic        m_valid_reg;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_tile_reg;
    logic [23:0] out_dist_reg;
    logic [21:0] out_x_reg, out_y_reg;

    dda_pkg::unit_req_t ureq;
    dda_pkg::unit_rsp_t ursp;

    logic        accept, out_free;
    logic [23:0] mul_a;
    logic [16:0] mul_b;
    logic [40:0] prod;
    logic [23:0] dsat;
    logic [16:0] remx, remy;
    logic [21:0] hit_val;
    logic [27:0] hit_sum;
    logic        hit_neg;
    logic [21:0] hit_org;
    logic        step_y;
    logic        oob;
    logic [7:0]  rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        wr_en;
    logic [5:0]  tx_low, ty_low;

    assign s_ready  = (state_reg == dda_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Map write path, read address and out-of-map test
    assign wr_en   = accept && (s_opcode == dda_pkg::OP_WRITE)
                   && ({1'b0, s_tile_col} < 7'(MAP_SIDE))
                   && ({1'b0, s_tile_row} < 7'(MAP_SIDE));
    assign wr_addr = AW'(s_tile_row) * AW'(MAP_SIDE) + AW'(s_tile_col);
    assign tx_low  = tx_reg[5:0];
    assign ty_low  = ty_reg[5:0];
    assign rd_addr = AW'(ty_low) * AW'(MAP_SIDE) + AW'(tx_low);
    assign oob     = tx_reg[7] || ty_reg[7]
                   || (tx_reg >= 8'(MAP_SIDE)) || (ty_reg >= 8'(MAP_SIDE));

    dda_map #(.MAP_SIDE(MAP_SIDE)) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tile_value),
        .rd_en   (state_reg == dda_pkg::S_BOUND),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ureq.start   = (state_reg == dda_pkg::S_SQ_GO)
                        || ((state_reg == dda_pkg::S_DX_GO) && (ax_reg != '0))
                        || ((state_reg == dda_pkg::S_DY_GO) && (ay_reg != '0));
    assign ureq.is_sqrt = (state_reg == dda_pkg::S_SQ_GO);

    dda_root_div u_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (ureq),
        .radicand ({sumsq_reg, 32'd0}),
        .dividend (root_reg),
        .divisor  ((state_reg == dda_pkg::S_DX_GO) ? ax_reg : ay_reg),
        .rsp      (ursp)
    );

    // Shared multiplier operand selection and hit point arithmetic
    always_comb begin
        dsat = (dist_reg > 34'(dda_pkg::DIST_MAX)) ? dda_pkg::DIST_MAX : dist_reg[23:0];
        remx = nx_reg ? {1'b0, ox_reg[15:0]} : 17'h10000 - {1'b0, ox_reg[15:0]};
        remy = ny_reg ? {1'b0, oy_reg[15:0]} : 17'h10000 - {1'b0, oy_reg[15:0]};
        case (state_reg)
            dda_pkg::S_SQX:  begin mul_a = {8'd0, ax_reg}; mul_b = {1'b0, ax_reg}; end
            dda_pkg::S_SQY:  begin mul_a = {8'd0, ay_reg}; mul_b = {1'b0, ay_reg}; end
            dda_pkg::S_REMX: begin mul_a = sx_reg; mul_b = remx; end
            dda_pkg::S_REMY: begin mul_a = sy_reg; mul_b = remy; end
            dda_pkg::S_HITX: begin mul_a = dsat; mul_b = {1'b0, ax_reg}; end
            default:         begin mul_a = dsat; mul_b = {1'b0, ay_reg}; end
        endcase
        prod    = 41'(mul_a) * 41'(mul_b);
        hit_neg = (state_reg == dda_pkg::S_HITX) ? nx_reg : ny_reg;
        hit_org = (state_reg == dda_pkg::S_HITX) ? ox_reg : oy_reg;
        hit_sum = {1'b0, prod[40:14]} + 28'(hit_org);
        if (hit_neg) begin
            hit_val = ({1'b0, prod[40:14]} >= 28'(hit_org)) ? 22'd0
                    : 22'(28'(hit_org) - {1'b0, prod[40:14]});
        end else begin
            hit_val = (hit_sum > 28'(dda_pkg::POS_MAX)) ? dda_pkg::POS_MAX : hit_sum[21:0];
        end
        step_y = !(rx_reg < ry_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dda_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_opcode == dda_pkg::OP_WRITE) begin
                        state_next = dda_pkg::S_HITY;
                    end else if (s_origin_x[21:16] >= 6'(MAP_SIDE - 1) + 6'd1 && MAP_SIDE < 64
                                 || s_origin_y[21:16] >= 6'(MAP_SIDE - 1) + 6'd1 && MAP_SIDE < 64) begin
                        state_next = dda_pkg::S_HITY;
                    end else begin
                        state_next = dda_pkg::S_SQX;
                    end
                end
            end
            dda_pkg::S_SQX:     state_next = dda_pkg::S_SQY;
            dda_pkg::S_SQY:     state_next = dda_pkg::S_SQ_GO;
            dda_pkg::S_SQ_GO:   state_next = dda_pkg::S_SQ_WAIT;
            dda_pkg::S_SQ_WAIT: if (ursp.done) state_next = dda_pkg::S_DX_GO;
            dda_pkg::S_DX_GO:   state_next = (ax_reg != '0) ? dda_pkg::S_DX_WAIT
                                                            : dda_pkg::S_DY_GO;
            dda_pkg::S_DX_WAIT: if (ursp.done) state_next = dda_pkg::S_DY_GO;
            dda_pkg::S_DY_GO:   state_next = (ay_reg != '0) ? dda_pkg::S_DY_WAIT
                                                            : dda_pkg::S_REMX;
            dda_pkg::S_DY_WAIT: if (ursp.done) state_next = dda_pkg::S_REMX;
            dda_pkg::S_REMX:    state_next = dda_pkg::S_REMY;
            dda_pkg::S_REMY:    state_next = dda_pkg::S_STEP;
            dda_pkg::S_STEP:    state_next = (count_reg < step_limit_reg) ? dda_pkg::S_BOUND
                                                                          : dda_pkg::S_HITX;
            dda_pkg::S_BOUND:   state_next = oob ? dda_pkg::S_HITX : dda_pkg::S_CHECK;
            dda_pkg::S_CHECK:   state_next = (rd_data >= wall_min_reg) ? dda_pkg::S_HITX
                                                                       : dda_pkg::S_STEP;
            dda_pkg::S_HITX:    state_next = dda_pkg::S_HITY;
            dda_pkg::S_HITY:    if (out_free) state_next = dda_pkg::S_IDLE;
            default:            state_next = dda_pkg::S_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dda_pkg::S_IDLE;
            wall_min_reg   <= 8'd1;
            step_limit_reg <= 8'd128;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_index == dda_pkg::REG_WALL_MIN) begin
                    wall_min_reg <= cfg_wdata;
                end else begin
                    step_limit_reg <= cfg_wdata;
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == dda_pkg::S_HITY && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            dda_pkg::S_IDLE: begin
                if (accept) begin
                    ox_reg    <= s_origin_x;
                    oy_reg    <= s_origin_y;
                    nx_reg    <= s_heading_x[15];
                    ny_reg    <= s_heading_y[15];
                    ax_reg    <= s_heading_x[15] ? 16'(-s_heading_x) : 16'(s_heading_x);
                    ay_reg    <= s_heading_y[15] ? 16'(-s_heading_y) : 16'(s_heading_y);
                    tx_reg    <= {2'b00, s_origin_x[21:16]};
                    ty_reg    <= {2'b00, s_origin_y[21:16]};
                    dist_reg  <= '0;
                    count_reg <= '0;
                    tile_reg  <= '0;
                    status_reg <= (s_opcode == dda_pkg::OP_WRITE) ? dda_pkg::ST_WRITE
                                                                  : dda_pkg::ST_LEFT;
                    hx_reg    <= (s_opcode == dda_pkg::OP_WRITE) ? 22'd0 : s_origin_x;
                end
            end
            dda_pkg::S_SQX: sumsq_reg <= prod[31:0];
            dda_pkg::S_SQY: sumsq_reg <= sumsq_reg + prod[31:0];
            dda_pkg::S_SQ_WAIT: if (ursp.done) root_reg <= ursp.result;
            dda_pkg::S_DX_GO: sx_reg <= dda_pkg::DIST_MAX;
            dda_pkg::S_DX_WAIT: if (ursp.done) begin
                sx_reg <= (ursp.result[31:24] != '0) ? dda_pkg::DIST_MAX : ursp.result[23:0];
            end
            dda_pkg::S_DY_GO: sy_reg <= dda_pkg::DIST_MAX;
            dda_pkg::S_DY_WAIT: if (ursp.done) begin
                sy_reg <= (ursp.result[31:24] != '0) ? dda_pkg::DIST_MAX : ursp.result[23:0];
            end
            dda_pkg::S_REMX: begin
                rx_reg     <= 34'(prod[40:16]);
                status_reg <= dda_pkg::ST_LIMIT;
            end
            dda_pkg::S_REMY: ry_reg <= 34'(prod[40:16]);
            dda_pkg::S_STEP: begin
                if (count_reg < step_limit_reg) begin
                    count_reg <= count_reg + 8'd1;
                    if (step_y) begin
                        dist_reg <= ry_reg;
                        ty_reg   <= ny_reg ? ty_reg - 8'sd1 : ty_reg + 8'sd1;
                        ry_reg   <= ry_reg + 34'(sy_reg);
                    end else begin
                        dist_reg <= rx_reg;
                        tx_reg   <= nx_reg ? tx_reg - 8'sd1 : tx_reg + 8'sd1;
                        rx_reg   <= rx_reg + 34'(sx_reg);
                    end
                end
            end
            dda_pkg::S_BOUND: if (oob) status_reg <= dda_pkg::ST_LEFT;
            dda_pkg::S_CHECK: begin
                if (rd_data >= wall_min_reg) begin
                    status_reg <= dda_pkg::ST_HIT;
                    tile_reg   <= rd_data;
                end
            end
            dda_pkg::S_HITX: hx_reg <= hit_val;
            dda_pkg::S_HITY: begin
                if (out_free) begin
                    out_status_reg <= status_reg;
                    out_tile_reg   <= tile_reg;
                    out_x_reg      <= hx_reg;
                    if (status_reg == dda_pkg::ST_WRITE) begin
                        out_dist_reg <= '0;
                        out_y_reg    <= '0;
                    end else begin
                        out_dist_reg <= dsat;
                        out_y_reg    <= hit_val;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_hit_tile     = out_tile_reg;
    assign m_hit_distance = out_dist_reg;
    assign m_hit_x        = out_x_reg;
    assign m_hit_y        = out_y_reg;
endmodule
`default_nettype wire
